>>> rtl/core/pl0_register_vm_execute_assert.svh
// Assertion macros shared by the execute block.
`ifndef PL0_REGISTER_VM_EXECUTE_ASSERT_SVH
`define PL0_REGISTER_VM_EXECUTE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RVM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RVM_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RVM_ASSERT(lbl, clk, rst, prop, msg)
`define RVM_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> rtl/core/rvm_pkg.sv
`default_nettype none
package rvm_pkg;

  localparam int RVM_NUM_REGS    = 16;
  localparam int RVM_STACK_DEPTH = 2048;

  typedef enum logic [4:0] {
    OP_LIT = 5'd0,  OP_RTN = 5'd1,  OP_LOD = 5'd2,  OP_STO = 5'd3,
    OP_CAL = 5'd4,  OP_INC = 5'd5,  OP_JMP = 5'd6,  OP_JPC = 5'd7,
    OP_SIO = 5'd8,  OP_NEG = 5'd9,  OP_ADD = 5'd10, OP_SUB = 5'd11,
    OP_MUL = 5'd12, OP_DIV = 5'd13, OP_ODD = 5'd14, OP_MOD = 5'd15,
    OP_EQL = 5'd16, OP_NEQ = 5'd17, OP_LSS = 5'd18, OP_LEQ = 5'd19,
    OP_GTR = 5'd20, OP_GEQ = 5'd21
  } opcode_t;

  localparam logic [15:0] SIO_OUT  = 16'd1;
  localparam logic [15:0] SIO_IN   = 16'd2;
  localparam logic [15:0] SIO_HALT = 16'd3;

  typedef enum logic [3:0] {
    OC_LIT, OC_RTN, OC_LOD, OC_STO, OC_CAL, OC_INC, OC_JMP,
    OC_JPC, OC_SIO, OC_NEG, OC_ODD, OC_ALU, OC_NOP
  } op_class_t;

  typedef enum logic [1:0] {
    SEL_WALK, SEL_BM, SEL_RB2, SEL_RB3
  } srd_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_RDA, ST_RDB, ST_DIVS, ST_DIVW,
    ST_WALK, ST_WALKW, ST_SRD, ST_CALL, ST_RTNA, ST_RTNB, ST_EXEC, ST_FIN
  } state_t;

  typedef struct packed {
    logic     cap;
    logic     dec;
    logic     rd_a;
    logic     rd_b;
    logic     s_rd;
    srd_sel_t srd_sel;
    logic     cur_ld;
    logic     lvl_dec;
    logic     set_flt;
    logic     call_wr;
    logic     div_start;
    logic     exec;
    logic     out_load;
    logic     clr_wr;
  } rvm_cmd_t;

  typedef struct packed {
    logic      halted;
    logic      idx_bad;
    op_class_t cls;
    logic      sio_reg;
    logic      is_div;
    logic      div_zero;
    logic      div_done;
    logic      lvl_zero;
    logic      walk_bad;
    logic      bm_bad;
    logic      call_bad;
    logic      rtn_bad;
    logic      call_last;
    logic      clr_last;
    logic      out_busy;
  } rvm_sts_t;

  function automatic op_class_t op_class(input logic [4:0] c);
    op_class_t k;
    case (c)
      OP_LIT: k = OC_LIT;
      OP_RTN: k = OC_RTN;
      OP_LOD: k = OC_LOD;
      OP_STO: k = OC_STO;
      OP_CAL: k = OC_CAL;
      OP_INC: k = OC_INC;
      OP_JMP: k = OC_JMP;
      OP_JPC: k = OC_JPC;
      OP_SIO: k = OC_SIO;
      OP_NEG: k = OC_NEG;
      OP_ODD: k = OC_ODD;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
      OP_EQL, OP_NEQ, OP_LSS, OP_LEQ, OP_GTR, OP_GEQ: k = OC_ALU;
      default: k = OC_NOP;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rvm_in_if.sv
`default_nettype none
interface rvm_in_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  cmd;
  logic        [3:0]  reg_sel;
  logic        [3:0]  level;
  logic signed [15:0] m_field;
  logic signed [31:0] in_value;

  modport source (output valid, cmd, reg_sel, level, m_field, in_value, input ready);
  modport sink   (input valid, cmd, reg_sel, level, m_field, in_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rvm_out_if.sv
`default_nettype none
interface rvm_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] next_pc;
  logic               halted;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic               fault;

  modport source (output valid, next_pc, halted, out_valid, out_value, fault, input ready);
  modport sink   (input valid, next_pc, halted, out_valid, out_value, fault, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rvm_div.sv
`default_nettype none
// Signed 32-bit divider, one restoring step per cycle, truncates toward zero.
module rvm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo,
  output logic signed [31:0] rem,
  output logic               done
);

  logic [31:0] ud;
  logic [31:0] qr;
  logic [31:0] rr;
  logic [4:0]  cnt;
  logic        busy;
  logic        qneg;
  logic        rneg;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rr, qr[31]};
  assign trial   = shifted - {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ud   <= den[31] ? 32'(-den) : 32'(den);
      qr   <= num[31] ? 32'(-num) : 32'(num);
      rr   <= '0;
      qneg <= num[31] ^ den[31];
      rneg <= num[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rr <= trial[31:0];
        qr <= {qr[30:0], 1'b1};
      end else begin
        rr <= shifted[31:0];
        qr <= {qr[30:0], 1'b0};
      end
    end
  end

  // magnitude of most negative / -1 wraps back to most negative
  assign quo = qneg ? -$signed(qr) : $signed(qr);
  assign rem = rneg ? -$signed(rr) : $signed(rr);

endmodule
`default_nettype wire

>>> rtl/core/rvm_dpath.sv
`default_nettype none
module rvm_dpath import rvm_pkg::*; #(
  parameter int NUM_REGS    = RVM_NUM_REGS,
  parameter int STACK_DEPTH = RVM_STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  rvm_cmd_t           cmd,
  output rvm_sts_t           sts,
  input  logic        [4:0]  in_cmd,
  input  logic        [3:0]  in_reg_sel,
  input  logic        [3:0]  in_level,
  input  logic signed [15:0] in_m_field,
  input  logic signed [31:0] in_in_value,
  input  logic               out_ready,
  output logic               out_full,
  output logic        [15:0] out_next_pc,
  output logic               out_halted,
  output logic               out_out_valid,
  output logic signed [31:0] out_out_value,
  output logic               out_fault
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam logic signed [33:0] DEPTH = 34'(STACK_DEPTH);
  localparam logic [16:0] NREG = 17'(NUM_REGS);
  localparam logic [SW-1:0] CLR_LAST = SW'(STACK_DEPTH - 1);

  function automatic logic in_stack(input logic signed [33:0] a);
    return (a >= 34'sd0) && (a < DEPTH);
  endfunction

  // captured instruction
  logic        [4:0]  q_cmd;
  logic        [3:0]  q_r;
  logic        [3:0]  q_lv;
  logic signed [15:0] q_m;
  logic signed [31:0] q_in;

  // machine state
  logic [31:0]       rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [31:0]       stack [STACK_DEPTH];
  logic [SW-1:0]     sp;
  logic [SW-1:0]     fb;
  logic [15:0]       pc;
  logic              halt;

  // working registers
  logic signed [31:0] cur;
  logic [3:0]         lvl_cnt;
  logic [1:0]         call_k;
  logic [SW-1:0]      clr_cnt;
  logic               flt_r;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic [31:0]        srd_q;
  logic               res_ov;
  logic signed [31:0] res_oval;
  logic               res_flt;

  op_class_t cls;
  logic [15:0] r16, lv16;
  logic r_ok, lv_ok, m_ok, sio_reg, is_div, idx_bad;
  logic [RW-1:0] r_idx, lv_idx, m_idx, a_idx;
  logic signed [33:0] fb_x, sp_x, cur_x, m_x;
  logic signed [33:0] walk_addr, bm_addr, rb2_addr, rb3_addr, inc_addr, call_top, sp1;
  logic signed [33:0] call_addr;
  logic walk_bad, bm_bad, call_bad, rtn_bad, inc_bad, nbp_bad, div_zero;
  logic signed [31:0] div_q, div_r;
  logic div_done;
  logic [SW-1:0] s_ra, st_wa;
  logic [31:0] st_wd, call_data;
  logic st_we;

  logic               ex_flt, rf_we, sto_do, ov, pc_we, sp_we, fb_we, halt_set;
  logic [31:0]        rf_wd;
  logic signed [31:0] oval, alu;
  logic [15:0]        pc_wd;
  logic [SW-1:0]      sp_wd, fb_wd;

  assign cls     = op_class(q_cmd);
  assign r16     = {12'b0, q_r};
  assign lv16    = {12'b0, q_lv};
  assign r_ok    = {1'b0, r16} < NREG;
  assign lv_ok   = {1'b0, lv16} < NREG;
  assign m_ok    = !q_m[15] && ({1'b0, q_m} < NREG);
  assign r_idx   = r16[RW-1:0];
  assign lv_idx  = lv16[RW-1:0];
  assign m_idx   = q_m[RW-1:0];
  assign a_idx   = (cls == OC_NEG || cls == OC_ALU) ? lv_idx : r_idx;
  assign sio_reg = (q_m == SIO_OUT) || (q_m == SIO_IN);
  assign is_div  = (q_cmd == OP_DIV) || (q_cmd == OP_MOD);
  assign div_zero = is_div && (opb == 32'sd0);

  always_comb begin
    case (cls)
      OC_LIT, OC_JPC, OC_ODD, OC_LOD, OC_STO: idx_bad = !r_ok;
      OC_SIO: idx_bad = sio_reg && !r_ok;
      OC_NEG: idx_bad = !r_ok || !lv_ok;
      OC_ALU: idx_bad = !r_ok || !lv_ok || !m_ok;
      default: idx_bad = 1'b0;
    endcase
  end

  assign fb_x      = 34'(fb);
  assign sp_x      = 34'(sp);
  assign cur_x     = 34'(cur);
  assign m_x       = 34'(q_m);
  assign walk_addr = cur_x + 34'sd1;
  assign bm_addr   = cur_x + m_x;
  assign rb2_addr  = fb_x + 34'sd2;
  assign rb3_addr  = fb_x + 34'sd3;
  assign inc_addr  = sp_x + m_x;
  assign call_top  = sp_x + 34'sd4;
  assign sp1       = sp_x + 34'sd1;
  assign call_addr = sp1 + 34'(call_k);

  assign walk_bad = !in_stack(walk_addr);
  assign bm_bad   = !in_stack(bm_addr);
  assign call_bad = !in_stack(call_top);
  assign rtn_bad  = (fb == '0) || !in_stack(rb3_addr);
  assign inc_bad  = !in_stack(inc_addr);
  assign nbp_bad  = !in_stack(cur_x);

  rvm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (opa),
    .den   (opb),
    .quo   (div_q),
    .rem   (div_r),
    .done  (div_done)
  );

  always_comb begin
    sts.halted    = halt;
    sts.idx_bad   = idx_bad;
    sts.cls       = cls;
    sts.sio_reg   = sio_reg;
    sts.is_div    = is_div;
    sts.div_zero  = div_zero;
    sts.div_done  = div_done;
    sts.lvl_zero  = (lvl_cnt == 4'd0);
    sts.walk_bad  = walk_bad;
    sts.bm_bad    = bm_bad;
    sts.call_bad  = call_bad;
    sts.rtn_bad   = rtn_bad;
    sts.call_last = (call_k == 2'd3);
    sts.clr_last  = (clr_cnt == CLR_LAST);
    sts.out_busy  = out_full && !out_ready;
  end

  always_comb begin
    case (q_cmd)
      OP_ADD:  alu = opa + opb;
      OP_SUB:  alu = opa - opb;
      OP_MUL:  alu = opa * opb;
      OP_DIV:  alu = div_q;
      OP_MOD:  alu = div_r;
      OP_EQL:  alu = {31'b0, opa == opb};
      OP_NEQ:  alu = {31'b0, opa != opb};
      OP_LSS:  alu = {31'b0, opa < opb};
      OP_LEQ:  alu = {31'b0, opa <= opb};
      OP_GTR:  alu = {31'b0, opa > opb};
      default: alu = {31'b0, opa >= opb};
    endcase
  end

  // commit decision for the current instruction
  always_comb begin
    ex_flt   = 1'b0;
    rf_we    = 1'b0;
    rf_wd    = '0;
    sto_do   = 1'b0;
    ov       = 1'b0;
    oval     = '0;
    pc_we    = 1'b0;
    pc_wd    = q_m;
    sp_we    = 1'b0;
    sp_wd    = sp;
    fb_we    = 1'b0;
    fb_wd    = fb;
    halt_set = 1'b0;
    if (!halt) begin
      case (cls)
        OC_LIT: begin
          if (idx_bad) ex_flt = 1'b1;
          else begin
            rf_we = 1'b1;
            rf_wd = 32'(q_m);
          end
        end
        OC_RTN: begin
          if (rtn_bad || nbp_bad) ex_flt = 1'b1;
          else begin
            pc_we = 1'b1;
            pc_wd = srd_q[15:0];
            sp_we = 1'b1;
            sp_wd = fb - SW'(1);
            fb_we = 1'b1;
            fb_wd = cur[SW-1:0];
          end
        end
        OC_LOD: begin
          if (idx_bad || flt_r || bm_bad) ex_flt = 1'b1;
          else begin
            rf_we = 1'b1;
            rf_wd = srd_q;
          end
        end
        OC_STO: begin
          if (idx_bad || flt_r || bm_bad) ex_flt = 1'b1;
          else sto_do = 1'b1;
        end
        OC_CAL: begin
          if (flt_r || call_bad) ex_flt = 1'b1;
          else begin
            fb_we = 1'b1;
            fb_wd = sp1[SW-1:0];
            pc_we = 1'b1;
          end
        end
        OC_INC: begin
          if (inc_bad) ex_flt = 1'b1;
          else begin
            sp_we = 1'b1;
            sp_wd = inc_addr[SW-1:0];
          end
        end
        OC_JMP: pc_we = 1'b1;
        OC_JPC: begin
          if (idx_bad) ex_flt = 1'b1;
          else if (opa == 32'sd0) pc_we = 1'b1;
        end
        OC_SIO: begin
          if (sio_reg) begin
            if (idx_bad) ex_flt = 1'b1;
            else if (q_m == SIO_OUT) begin
              ov   = 1'b1;
              oval = opa;
            end else begin
              rf_we = 1'b1;
              rf_wd = q_in;
            end
          end else if (q_m == SIO_HALT) begin
            halt_set = 1'b1;
          end
        end
        OC_NEG: begin
          if (idx_bad) ex_flt = 1'b1;
          else begin
            rf_we = 1'b1;
            rf_wd = -opa;
          end
        end
        OC_ODD: begin
          if (idx_bad) ex_flt = 1'b1;
          else begin
            rf_we = 1'b1;
            // truncated remainder: odd negatives give -1
            rf_wd = opa[0] ? (opa[31] ? '1 : 32'd1) : 32'd0;
          end
        end
        OC_ALU: begin
          if (idx_bad || div_zero) ex_flt = 1'b1;
          else begin
            rf_we = 1'b1;
            rf_wd = alu;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (call_k)
      2'd0:    call_data = '0;
      2'd1:    call_data = cur;
      2'd2:    call_data = 32'(fb);
      default: call_data = 32'(pc);
    endcase
  end

  always_comb begin
    case (cmd.srd_sel)
      SEL_WALK: s_ra = walk_addr[SW-1:0];
      SEL_BM:   s_ra = bm_addr[SW-1:0];
      SEL_RB2:  s_ra = rb2_addr[SW-1:0];
      default:  s_ra = rb3_addr[SW-1:0];
    endcase
  end

  always_comb begin
    st_we = 1'b0;
    st_wa = clr_cnt;
    st_wd = '0;
    if (cmd.clr_wr) begin
      st_we = 1'b1;
    end else if (cmd.call_wr) begin
      st_we = 1'b1;
      st_wa = call_addr[SW-1:0];
      st_wd = call_data;
    end else if (cmd.exec && sto_do) begin
      st_we = 1'b1;
      st_wa = bm_addr[SW-1:0];
      st_wd = opa;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) stack[st_wa] <= st_wd;
    if (cmd.s_rd) srd_q <= stack[s_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && rf_we) rf[r_idx] <= rf_wd;
    if (cmd.rd_a) opa <= rf_vld[a_idx] ? $signed(rf[a_idx]) : 32'sd0;
    if (cmd.rd_b) opb <= rf_vld[m_idx] ? $signed(rf[m_idx]) : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld   <= '0;
      sp       <= '0;
      fb       <= SW'(1);
      pc       <= '0;
      halt     <= 1'b0;
      clr_cnt  <= '0;
      out_full <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + SW'(1);
      if (cmd.exec) begin
        if (rf_we)    rf_vld[r_idx] <= 1'b1;
        if (pc_we)    pc <= pc_wd;
        if (sp_we)    sp <= sp_wd;
        if (fb_we)    fb <= fb_wd;
        if (halt_set) halt <= 1'b1;
      end
      if (cmd.out_load)  out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      q_cmd <= in_cmd;
      q_r   <= in_reg_sel;
      q_lv  <= in_level;
      q_m   <= in_m_field;
      q_in  <= in_in_value;
    end
    if (cmd.dec) begin
      cur     <= 32'(fb);
      lvl_cnt <= q_lv;
      call_k  <= '0;
      flt_r   <= 1'b0;
    end
    if (cmd.cur_ld)  cur <= $signed(srd_q);
    if (cmd.lvl_dec) lvl_cnt <= lvl_cnt - 4'd1;
    if (cmd.set_flt) flt_r <= 1'b1;
    if (cmd.call_wr) call_k <= call_k + 2'd1;
    if (cmd.exec) begin
      res_ov   <= ov;
      res_oval <= oval;
      res_flt  <= ex_flt;
    end
    if (cmd.out_load) begin
      out_next_pc   <= pc;
      out_halted    <= halt;
      out_out_valid <= res_ov;
      out_out_value <= res_oval;
      out_fault     <= res_flt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rvm_ctrl.sv
`default_nettype none
`include "pl0_register_vm_execute_assert.svh"
module rvm_ctrl import rvm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rvm_sts_t sts,
  output rvm_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.dec = 1'b1;
        if (sts.halted || sts.idx_bad) state_next = ST_EXEC;
        else begin
          case (sts.cls)
            OC_SIO: state_next = sts.sio_reg ? ST_RDA : ST_EXEC;
            OC_JPC, OC_ODD, OC_NEG, OC_ALU, OC_STO: state_next = ST_RDA;
            OC_LOD, OC_CAL: state_next = ST_WALK;
            OC_RTN: state_next = sts.rtn_bad ? ST_EXEC : ST_RTNA;
            default: state_next = ST_EXEC;
          endcase
        end
      end
      ST_RDA: begin
        cmd.rd_a = 1'b1;
        if (sts.cls == OC_ALU)      state_next = ST_RDB;
        else if (sts.cls == OC_STO) state_next = ST_WALK;
        else                        state_next = ST_EXEC;
      end
      ST_RDB: begin
        cmd.rd_b   = 1'b1;
        state_next = sts.is_div ? ST_DIVS : ST_EXEC;
      end
      ST_DIVS: begin
        if (sts.div_zero) state_next = ST_EXEC;
        else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (sts.div_done) state_next = ST_EXEC;
      end
      ST_WALK: begin
        // one static link per pass; at the end pick the access that follows
        if (sts.lvl_zero) begin
          case (sts.cls)
            OC_LOD:  state_next = sts.bm_bad ? ST_EXEC : ST_SRD;
            OC_CAL:  state_next = sts.call_bad ? ST_EXEC : ST_CALL;
            default: state_next = ST_EXEC;
          endcase
        end else if (sts.walk_bad) begin
          cmd.set_flt = 1'b1;
          state_next  = ST_EXEC;
        end else begin
          cmd.s_rd    = 1'b1;
          cmd.srd_sel = SEL_WALK;
          state_next  = ST_WALKW;
        end
      end
      ST_WALKW: begin
        cmd.cur_ld  = 1'b1;
        cmd.lvl_dec = 1'b1;
        state_next  = ST_WALK;
      end
      ST_SRD: begin
        cmd.s_rd    = 1'b1;
        cmd.srd_sel = SEL_BM;
        state_next  = ST_EXEC;
      end
      ST_CALL: begin
        cmd.call_wr = 1'b1;
        if (sts.call_last) state_next = ST_EXEC;
      end
      ST_RTNA: begin
        cmd.s_rd    = 1'b1;
        cmd.srd_sel = SEL_RB2;
        state_next  = ST_RTNB;
      end
      ST_RTNB: begin
        cmd.cur_ld  = 1'b1;
        cmd.s_rd    = 1'b1;
        cmd.srd_sel = SEL_RB3;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RVM_ASSERT(a_cap_decode, clk, rst, cmd.cap |=> state == ST_DECODE, "capture not followed by decode")
  `RVM_ASSERT(a_div_done, clk, rst, sts.div_done |-> state == ST_DIVW, "divider finished outside wait")
  `RVM_NEVER(a_call_range, clk, rst, cmd.call_wr && sts.call_bad, "record write out of range")
  `RVM_NEVER(a_out_over, clk, rst, cmd.out_load && sts.out_busy, "result overwrites pending beat")

endmodule
`default_nettype wire

>>> rtl/core/pl0_register_vm_execute.sv
`default_nettype none
// Channel  Dir  Beat contents
// instr    in   cmd, reg_sel, level, m_field, in_value
// result   out  next_pc, halted, out_valid, out_value, fault
//
// One instruction at a time. lit/inc/jmp go from decode straight to execute; single-register
// ops read one register, two-register ops read two, and rtn reads two words of its record.
// lod/sto/cal walk the static levels, one data stack read per level walked; cal then
// writes its call record, and div/mod wait on the 1-bit-per-cycle divider. After reset
// a clearing pass writes zeros to every data stack entry, with instr.ready held low.
// A stalled result waits in the output register while the next beat is taken and executed.
module pl0_register_vm_execute import rvm_pkg::*; #(
  parameter int NUM_REGS    = RVM_NUM_REGS,
  parameter int STACK_DEPTH = RVM_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  rvm_in_if.sink    instr,
  rvm_out_if.source result
);

  rvm_cmd_t cmd;
  rvm_sts_t sts;

  rvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (instr.valid),
    .in_ready (instr.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rvm_dpath #(
    .NUM_REGS    (NUM_REGS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_cmd        (instr.cmd),
    .in_reg_sel    (instr.reg_sel),
    .in_level      (instr.level),
    .in_m_field    (instr.m_field),
    .in_in_value   (instr.in_value),
    .out_ready     (result.ready),
    .out_full      (result.valid),
    .out_next_pc   (result.next_pc),
    .out_halted    (result.halted),
    .out_out_valid (result.out_valid),
    .out_out_value (result.out_value),
    .out_fault     (result.fault)
  );

endmodule
`default_nettype wire
